// ----- src/random_sample_set_macros.svh -----
// ----------------------------------------------------------------------------
// Random sample set assertion macros
// Shared property templates for the random sample set checks.
// ----------------------------------------------------------------------------
`ifndef RANDOM_SAMPLE_SET_MACROS_SVH
`define RANDOM_SAMPLE_SET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// Random sample set package
// Field widths, action and status codes, and the cell control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rss_pkg;

   localparam int DATA_W         = 32;
   localparam int ACTION_W       = 2;
   localparam int STATUS_W       = 2;
   localparam int MEMBER_COUNT_W = 7;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NO_CHANGE = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Control strobes broadcast from the sequencer to every cell.
   typedef struct packed {
      logic capture;  // latch the match flag of this item
      logic ins_we;   // write the key into the cell at the count position
      logic rem_we;   // write the read bus value into the matching cell
   } cell_ctrl_type;

endpackage

// ----- src/rss_cell.sv -----
// ----------------------------------------------------------------------------
// Random sample set cell
// Holds one entry, compares it with the key and forwards the read bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                        clock,
   input  rss_pkg::cell_ctrl_type      ctrl,
   input  logic [rss_pkg::DATA_W-1:0]  key,
   input  logic [rss_pkg::DATA_W-1:0]  wr_data,
   input  logic [CNT_W-1:0]            count,
   input  logic [IDX_W-1:0]            sel_idx,
   input  logic [rss_pkg::DATA_W-1:0]  bus_in,
   output logic [rss_pkg::DATA_W-1:0]  bus_out,
   output logic                        hit
);

   logic [rss_pkg::DATA_W-1:0] value_ff;
   logic [rss_pkg::DATA_W-1:0] value_in;
   logic [rss_pkg::DATA_W-1:0] bus_ff;
   logic [rss_pkg::DATA_W-1:0] bus_in_next;
   logic                       hit_ff;
   logic                       hit_in;
   logic                       occupied;
   logic                       selected;

   assign occupied = CNT_W'(INDEX) < count;
   assign hit      = occupied && (value_ff == key);
   assign selected = sel_idx == IDX_W'(INDEX);

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_we && (count == CNT_W'(INDEX))) begin
         value_in = key;
      end else if (ctrl.rem_we && hit_ff) begin
         value_in = wr_data;
      end
   end

   assign hit_in      = ctrl.capture ? hit : hit_ff;
   assign bus_in_next = bus_in | (selected ? value_ff : '0);
   assign bus_out     = bus_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
      bus_ff   <= bus_in_next;
   end

endmodule

// ----- src/rss_mod.sv -----
// ----------------------------------------------------------------------------
// Random sample set modulo unit
// Restoring remainder of a 32-bit draw by the member count, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_mod #(
   parameter int CNT_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rss_pkg::DATA_W-1:0]  dividend,
   input  logic [CNT_W-1:0]            divisor,
   output logic                        done,
   output logic [CNT_W-1:0]            remainder
);

   localparam int BIT_W = $clog2(rss_pkg::DATA_W);

   logic                       busy_ff;
   logic                       busy_in;
   logic                       done_ff;
   logic                       done_in;
   logic [BIT_W-1:0]           bit_cnt_ff;
   logic [BIT_W-1:0]           bit_cnt_in;
   logic [rss_pkg::DATA_W-1:0] dividend_ff;
   logic [rss_pkg::DATA_W-1:0] dividend_in;
   logic [CNT_W-1:0]           rem_ff;
   logic [CNT_W-1:0]           rem_in;
   logic [CNT_W:0]             trial;
   logic [CNT_W:0]             divisor_ext;
   logic                       last_bit;

   assign trial       = {rem_ff, dividend_ff[rss_pkg::DATA_W-1]};
   assign divisor_ext = {1'b0, divisor};
   assign last_bit    = bit_cnt_ff == BIT_W'(rss_pkg::DATA_W - 1);

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      bit_cnt_in  = bit_cnt_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         bit_cnt_in  = '0;
         dividend_in = dividend;
         rem_in      = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         rem_in      = (trial >= divisor_ext) ? CNT_W'(trial - divisor_ext) : CNT_W'(trial);
         dividend_in = {dividend_ff[rss_pkg::DATA_W-2:0], 1'b0};
         bit_cnt_in  = bit_cnt_ff + BIT_W'(1);
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/random_sample_set.sv -----
// ----------------------------------------------------------------------------
// Random sample set
// A set of distinct 32-bit values with insert, remove and random sample.
// ----------------------------------------------------------------------------
// Usage: each request beat on the req_ channel carries an action (insert,
// remove or sample), an element value and a random draw. Every request beat
// yields exactly one response beat on the rsp_ channel with a status, the
// sampled member (zero unless a sample succeeds) and the member count.
// The block works on one request at a time; req_stall is low only while it
// is idle. The entries live in a row of CAPACITY cells that all compare
// their entry with the key in the same cycle. Reads of one entry (the last
// entry for a remove, the drawn entry for a sample) travel down a registered
// read bus from cell to cell. Each request passes through a match step and
// then a finish step that loads the response; a successful remove adds a
// read of the last entry in between, and a successful sample adds a
// bit-serial modulo of the draw by the member count and then a read of the
// drawn entry.
// A new request is taken in the cycle after the previous response is loaded.
// If the receiver stalls, the response holds and the next finished result
// waits in the block until the response beat is taken.
// Reset (synchronous, active high) empties the set and drops any response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "random_sample_set_macros.svh"

module random_sample_set #(
   parameter int CAPACITY = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [rss_pkg::ACTION_W-1:0]             req_action,
   input  logic signed [rss_pkg::DATA_W-1:0]        req_element_value,
   input  logic [rss_pkg::DATA_W-1:0]               req_random_draw,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [rss_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [rss_pkg::DATA_W-1:0]        rsp_sampled_value,
   output logic [rss_pkg::MEMBER_COUNT_W-1:0]       rsp_member_count
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W = rss_pkg::DATA_W;
   localparam int MCW    = rss_pkg::MEMBER_COUNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_MOD,
      S_READ,
      S_FINISH
   } state_type;

   state_type                   state_ff;
   state_type                   state_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [rss_pkg::ACTION_W-1:0] act_ff;
   logic [rss_pkg::ACTION_W-1:0] act_in;
   logic [DATA_W-1:0]           key_ff;
   logic [DATA_W-1:0]           key_in;
   logic [DATA_W-1:0]           draw_ff;
   logic [DATA_W-1:0]           draw_in;
   logic [IDX_W-1:0]            sel_ff;
   logic [IDX_W-1:0]            sel_in;
   logic [CNT_W-1:0]            rd_cnt_ff;
   logic [CNT_W-1:0]            rd_cnt_in;
   rss_pkg::status_type         res_status_ff;
   rss_pkg::status_type         res_status_in;
   logic [DATA_W-1:0]           res_sample_ff;
   logic [DATA_W-1:0]           res_sample_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [rss_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [rss_pkg::STATUS_W-1:0] rsp_status_in;
   logic [DATA_W-1:0]           rsp_sampled_ff;
   logic [DATA_W-1:0]           rsp_sampled_in;
   logic [MCW-1:0]              rsp_count_ff;
   logic [MCW-1:0]              rsp_count_in;

   rss_pkg::cell_ctrl_type      cell_ctrl;
   logic [CAPACITY-1:0]         hit_vec;
   logic [DATA_W-1:0]           bus [CAPACITY+1];
   logic                        any_hit;
   logic                        read_done;
   logic                        req_accept;
   logic                        rsp_load;
   logic                        mod_start;
   logic                        mod_done;
   logic [CNT_W-1:0]            mod_rem;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != S_IDLE;
   assign any_hit    = |hit_vec;
   assign read_done  = (state_ff == S_READ) && (rd_cnt_ff == CNT_W'(CAPACITY));
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // The read bus enters empty at the far end of the row.
   assign bus[CAPACITY] = '0;

   // Row of entry cells. Cell i holds the entry at index i.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rss_cell #(
         .INDEX (i),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .ctrl    (cell_ctrl),
         .key     (key_ff),
         .wr_data (bus[0]),
         .count   (count_ff),
         .sel_idx (sel_ff),
         .bus_in  (bus[i+1]),
         .bus_out (bus[i]),
         .hit     (hit_vec[i])
      );
   end

   rss_mod #(
      .CNT_W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (draw_ff),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      act_in         = act_ff;
      key_in         = key_ff;
      draw_in        = draw_ff;
      sel_in         = sel_ff;
      rd_cnt_in      = rd_cnt_ff;
      res_status_in  = res_status_ff;
      res_sample_in  = res_sample_ff;
      cell_ctrl      = '0;
      mod_start      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_sampled_in = rsp_sampled_ff;
      rsp_count_in   = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               act_in   = req_action;
               key_in   = req_element_value;
               draw_in  = req_random_draw;
               state_in = S_MATCH;
            end
         end

         S_MATCH: begin
            // All occupied cells compare their entry with the key this cycle.
            cell_ctrl.capture = 1'b1;
            res_sample_in     = '0;
            res_status_in     = rss_pkg::ST_NO_CHANGE;
            state_in          = S_FINISH;
            case (act_ff)
               rss_pkg::ACT_INSERT: begin
                  if (any_hit) begin
                     res_status_in = rss_pkg::ST_NO_CHANGE;
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = rss_pkg::ST_FULL;
                  end else begin
                     cell_ctrl.ins_we = 1'b1;
                     count_in         = count_ff + CNT_W'(1);
                     res_status_in    = rss_pkg::ST_DONE;
                  end
               end
               rss_pkg::ACT_REMOVE: begin
                  // The last entry is fetched and moved into the matching slot.
                  if (any_hit) begin
                     sel_in    = IDX_W'(count_ff - CNT_W'(1));
                     rd_cnt_in = '0;
                     state_in  = S_READ;
                  end
               end
               rss_pkg::ACT_SAMPLE: begin
                  if (count_ff == '0) begin
                     res_status_in = rss_pkg::ST_EMPTY;
                  end else begin
                     mod_start = 1'b1;
                     state_in  = S_MOD;
                  end
               end
               default: begin
                  res_status_in = rss_pkg::ST_NO_CHANGE;
               end
            endcase
         end

         S_MOD: begin
            if (mod_done) begin
               sel_in    = IDX_W'(mod_rem);
               rd_cnt_in = '0;
               state_in  = S_READ;
            end
         end

         S_READ: begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            if (read_done) begin
               rd_cnt_in     = rd_cnt_ff;
               res_status_in = rss_pkg::ST_DONE;
               state_in      = S_FINISH;
               if (act_ff == rss_pkg::ACT_REMOVE) begin
                  cell_ctrl.rem_we = 1'b1;
                  count_in         = count_ff - CNT_W'(1);
               end else begin
                  res_sample_in = bus[0];
               end
            end
         end

         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_sampled_in = res_sample_ff;
               rsp_count_in   = MCW'(count_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      key_ff         <= key_in;
      draw_ff        <= draw_in;
      sel_ff         <= sel_in;
      rd_cnt_ff      <= rd_cnt_in;
      res_status_ff  <= res_status_in;
      res_sample_ff  <= res_sample_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sampled_ff <= rsp_sampled_in;
      rsp_count_ff   <= rsp_count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_sampled_value = rsp_sampled_ff;
   assign rsp_member_count  = rsp_count_ff;

   // The occupancy never passes the capacity of the cell row.
   `RSS_ASSERT_SAME(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   // Occupancy changes only on an insert decision or at the end of a remove read.
   `RSS_ASSERT_NEXT(a_count_hold, clock, reset, (state_ff != S_MATCH) && !read_done, $stable(count_ff), "count changed outside an update")
   // Occupied entries are distinct, so at most one cell can match the key.
   `RSS_ASSERT_SAME(a_hit_unique, clock, reset, 1'b1, $onehot0(hit_vec), "more than one cell matched")
   // The modulo unit only finishes while the sequencer waits for it.
   `RSS_ASSERT_SAME(a_mod_done_state, clock, reset, mod_done, state_ff == S_MOD, "modulo done outside wait")
   // An empty report always carries a zero sample and a zero count.
   `RSS_ASSERT_SAME(a_empty_resp, clock, reset, rsp_valid_ff && (rsp_status_ff == rss_pkg::ST_EMPTY), (rsp_sampled_ff == '0) && (rsp_count_ff == '0), "empty response carries data")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Random sample set testbench
// Sends insert, remove and sample requests into random_sample_set, keeps its
// own copy of the set, and checks every response beat field by field. The
// run covers the empty and full corners, field extremes, the unused action
// code, random traffic with idling on both sides, and a long response stall
// that backs the block up into its request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int DATA_W           = rss_pkg::DATA_W;
   localparam int ACTION_W         = rss_pkg::ACTION_W;
   localparam int STATUS_W         = rss_pkg::STATUS_W;
   localparam int MEMBER_COUNT_W   = rss_pkg::MEMBER_COUNT_W;

   localparam int SET_CAPACITY     = 64;
   localparam int CLOCK_HALF       = 4;
   localparam int RESET_CYCLES     = 4;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int POOL_SIZE        = 96;
   // A successful sample is the slowest request: the bit-serial modulo plus
   // the walk down the read bus. Allow that twice over after the last beat.
   localparam int SETTLE_CYCLES    = 2 * (SET_CAPACITY + 36) + 20;

   // Action code three has no meaning; the block must treat it as a no-op.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // One response beat as the block should produce it.
   typedef struct {
      rss_pkg::status_type        status;
      logic signed [DATA_W-1:0]   sampled;
      logic [MEMBER_COUNT_W-1:0]  count;
   } set_response_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [ACTION_W-1:0]              req_action;
   logic signed [DATA_W-1:0]         req_element_value;
   logic [DATA_W-1:0]                req_random_draw;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [STATUS_W-1:0]              rsp_status;
   logic signed [DATA_W-1:0]         rsp_sampled_value;
   logic [MEMBER_COUNT_W-1:0]        rsp_member_count;

   // Bench copy of the set: a dense array of members and the member count.
   logic signed [DATA_W-1:0]  member_values [SET_CAPACITY];
   int                        member_total = 0;

   // Values that the random traffic keeps returning to, so that inserts
   // collide with members and removes find them.
   logic signed [DATA_W-1:0]  value_pool [POOL_SIZE];

   // Responses owed by the block, oldest first.
   set_response_type          pending_responses[$];

   bit  offering          = 1'b0;
   bit  sender_idling     = 1'b0;
   bit  receiver_idling   = 1'b0;
   bit  long_hold_pending = 1'b0;
   bit  long_hold_active  = 1'b0;

   int  mismatch_count    = 0;
   int  requests_sent     = 0;
   int  responses_seen    = 0;
   int  status_seen [4]   = '{0, 0, 0, 0};
   int  peak_members      = 0;
   int  longest_wait      = 0;
   int  cycle_count       = 0;

   random_sample_set #(
      .CAPACITY (SET_CAPACITY)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_element_value (req_element_value),
      .req_random_draw   (req_random_draw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_sampled_value (rsp_sampled_value),
      .rsp_member_count  (rsp_member_count)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // A hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses still owed.",
                  cycle_count, pending_responses.size());
         $display("testbench: errors");
         $finish;
      end
   end

   // Applies one request to the bench copy of the set and returns the
   // response it must produce. Membership is looked up first, so an insert
   // of a present value reports no change even when the set is full.
   function automatic set_response_type apply_set_action(
      input logic [ACTION_W-1:0]     act,
      input logic signed [DATA_W-1:0] value,
      input logic [DATA_W-1:0]       draw
   );
      set_response_type resp;
      int               slot;
      int               i;
      slot         = -1;
      resp.status  = rss_pkg::ST_NO_CHANGE;
      resp.sampled = '0;
      for (i = 0; i < member_total; i++) begin
         if (slot < 0 && member_values[i] == value)
            slot = i;
      end
      case (act)
         rss_pkg::ACT_INSERT: begin
            if (slot >= 0) begin
               resp.status = rss_pkg::ST_NO_CHANGE;
            end else if (member_total >= SET_CAPACITY) begin
               resp.status = rss_pkg::ST_FULL;
            end else begin
               member_values[member_total] = value;
               member_total++;
               resp.status = rss_pkg::ST_DONE;
            end
         end
         rss_pkg::ACT_REMOVE: begin
            // The last member fills the hole left by the removed one.
            if (slot >= 0) begin
               member_values[slot] = member_values[member_total - 1];
               member_total--;
               resp.status = rss_pkg::ST_DONE;
            end
         end
         rss_pkg::ACT_SAMPLE: begin
            if (member_total == 0) begin
               resp.status = rss_pkg::ST_EMPTY;
            end else begin
               resp.sampled = member_values[draw % DATA_W'(member_total)];
               resp.status  = rss_pkg::ST_DONE;
            end
         end
         default: begin
            // The unused code leaves the set alone and reports no change.
         end
      endcase
      resp.count = MEMBER_COUNT_W'(member_total);
      if (member_total > peak_members)
         peak_members = member_total;
      return resp;
   endfunction

   // Draws lean toward small numbers and the top of the 32-bit range, where
   // the modulo by the member count is most likely to go wrong.
   function automatic logic [DATA_W-1:0] pick_draw();
      logic [DATA_W-1:0] draw;
      case ($urandom_range(0, 3))
         0:       draw = $urandom_range(0, 2 * SET_CAPACITY);
         1:       draw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
         default: draw = $urandom;
      endcase
      return draw;
   endfunction

   // Offers one request beat and returns once the block has taken it. Valid
   // stays high after acceptance so that back-to-back beats need only one
   // assignment per clock edge; it is lowered only ahead of an idle gap or
   // when the sequence pauses.
   task automatic offer_request(
      input logic [ACTION_W-1:0]      act,
      input logic signed [DATA_W-1:0] value,
      input logic [DATA_W-1:0]        draw
   );
      int               waited;
      set_response_type owed;
      waited = 0;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_element_value <= value;
      req_random_draw   <= draw;
      offering = 1'b1;
      // The beat is taken at the first edge where the block is not stalling.
      do begin
         @(posedge clock);
         waited++;
      end while (req_stall !== 1'b0);
      if (waited > longest_wait)
         longest_wait = waited;
      owed = apply_set_action(act, value, draw);
      pending_responses = {pending_responses, owed};
      requests_sent++;
   endtask

   // Stops offering and waits until every owed response has come back.
   task automatic drain_responses();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_responses.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Every response beat is matched against the oldest owed response.
   always @(posedge clock) begin : check_response
      set_response_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         responses_seen++;
         if (pending_responses.size() == 0) begin
            $error("Response beat arrived with no request outstanding.");
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_sampled_value !== want.sampled) begin
               $error("sampled_value mismatch: expected %0d, actual %0d",
                      want.sampled, rsp_sampled_value);
               mismatch_count++;
            end
            if (rsp_member_count !== want.count) begin
               $error("member_count mismatch: expected %0d, actual %0d",
                      want.count, rsp_member_count);
               mismatch_count++;
            end
         end
      end
   end

   // Paces the response side. Short stall bursts come at random while
   // receiver idling is on; a long hold, when one is asked for, is counted
   // here so that the request side keeps offering beats meanwhile.
   initial begin : response_pacing
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            rsp_stall <= 1'b1;
            long_hold_active = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_pending = 1'b0;
            long_hold_active  = 1'b0;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // An empty set: samples report empty with a zero value, and removes of
   // anything report no change.
   task automatic test_empty_set();
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'd0);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'hFFFF_FFFF);
      offer_request(rss_pkg::ACT_REMOVE, 32'sd0, 32'd0);
      offer_request(rss_pkg::ACT_REMOVE, 32'sh8000_0000, 32'd0);
   endtask

   // The signed extremes as members, a duplicate insert, samples at both
   // ends of the draw range, and removes of a middle entry (the last entry
   // moves into its slot), of the last entry and of an absent value.
   task automatic test_field_extremes();
      offer_request(rss_pkg::ACT_INSERT, 32'sh8000_0000, 32'd0);
      offer_request(rss_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      offer_request(rss_pkg::ACT_INSERT, 32'sd0, 32'd0);
      offer_request(rss_pkg::ACT_INSERT, -32'sd1, 32'd0);
      offer_request(rss_pkg::ACT_INSERT, 32'sh8000_0000, 32'd0);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'd0);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'd2);
      offer_request(rss_pkg::ACT_REMOVE, 32'sd0, 32'd0);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'd2);
      offer_request(rss_pkg::ACT_REMOVE, -32'sd1, 32'd0);
      offer_request(rss_pkg::ACT_REMOVE, 32'sd12345, 32'd0);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'h8000_0000);
      offer_request(rss_pkg::ACT_REMOVE, 32'sh8000_0000, 32'd0);
      offer_request(rss_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, 32'd0);
      offer_request(rss_pkg::ACT_SAMPLE, 32'sd0, 32'd1);
   endtask

   // The unused action code must neither insert nor remove its value.
   task automatic test_unused_action();
      offer_request(ACT_UNUSED, 32'sd5, 32'd3);
      offer_request(rss_pkg::ACT_INSERT, 32'sd7, 32'd0);
      offer_request(ACT_UNUSED, 32'sd7, 32'hFFFF_FFFF);
      offer_request(rss_pkg::ACT_REMOVE, 32'sd5, 32'd0);
      offer_request(rss_pkg::ACT_REMOVE, 32'sd7, 32'd0);
   endtask

   // Fills the set to capacity with random values, pushes on the full
   // corner, then removes members in random order until the set is empty.
   task automatic test_fill_and_drain();
      int step;
      step = 0;
      while (member_total < SET_CAPACITY) begin
         offer_request(rss_pkg::ACT_INSERT, $urandom, pick_draw());
         step++;
         if (step % 8 == 0)
            offer_request(rss_pkg::ACT_SAMPLE, $urandom, pick_draw());
      end
      // New values bounce off a full set; a present value still reports
      // no change, since membership is checked before fullness.
      repeat (3) offer_request(rss_pkg::ACT_INSERT, $urandom, pick_draw());
      offer_request(rss_pkg::ACT_INSERT,
                    member_values[$urandom_range(0, SET_CAPACITY - 1)], pick_draw());
      offer_request(rss_pkg::ACT_SAMPLE, $urandom, SET_CAPACITY - 1);
      offer_request(rss_pkg::ACT_SAMPLE, $urandom, SET_CAPACITY);
      offer_request(rss_pkg::ACT_SAMPLE, $urandom, 32'hFFFF_FFFF);
      while (member_total > 0) begin
         offer_request(rss_pkg::ACT_REMOVE,
                       member_values[$urandom_range(0, member_total - 1)], pick_draw());
         step++;
         if (step % 6 == 0)
            offer_request(rss_pkg::ACT_SAMPLE, $urandom, pick_draw());
         if (step % 10 == 0)
            offer_request(rss_pkg::ACT_REMOVE, $urandom, pick_draw());
      end
      offer_request(rss_pkg::ACT_SAMPLE, $urandom, pick_draw());
   endtask

   // Random traffic over the value pool. Inserts slightly outnumber removes
   // so the set keeps climbing into the full corner, and most removes name a
   // present member. With idling allowed, each stretch of 40 beats picks
   // afresh whether either side idles, so quiet stretches occur too.
   task automatic test_random_mix(input int beat_total, input bit allow_idling);
      int                       n;
      int                       pick;
      logic [ACTION_W-1:0]      act;
      logic signed [DATA_W-1:0] value;
      for (n = 0; n < beat_total; n++) begin
         if (n % 40 == 0) begin
            sender_idling   = allow_idling && $urandom_range(0, 3) != 0;
            receiver_idling = allow_idling && $urandom_range(0, 3) != 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 42)
            act = rss_pkg::ACT_INSERT;
         else if (pick < 72)
            act = rss_pkg::ACT_REMOVE;
         else if (pick < 95)
            act = rss_pkg::ACT_SAMPLE;
         else
            act = ACT_UNUSED;
         pick = $urandom_range(0, 99);
         if (act == rss_pkg::ACT_REMOVE && member_total > 0 && pick < 70)
            value = member_values[$urandom_range(0, member_total - 1)];
         else if (act != rss_pkg::ACT_SAMPLE && pick < 88)
            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            value = $urandom;
         offer_request(act, value, pick_draw());
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block fills its response slot and its waiting result and then
   // has to stall the request channel.
   task automatic test_response_backpressure();
      int n;
      // The last beat is already taken; stop offering it while the hold
      // starts.
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      long_hold_pending = 1'b1;
      wait (long_hold_active);
      for (n = 0; n < 12; n++)
         offer_request(n % 3 == 2 ? rss_pkg::ACT_SAMPLE : rss_pkg::ACT_INSERT,
                       value_pool[$urandom_range(0, POOL_SIZE - 1)], pick_draw());
   endtask

   initial begin : run_sequence
      int i;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= rss_pkg::ACT_INSERT;
      req_element_value <= '0;
      req_random_draw   <= '0;
      // The pool keeps the signed extremes and zero next to random values.
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      for (i = 4; i < POOL_SIZE; i++)
         value_pool[i] = $urandom;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks run with some idling on both sides.
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      test_empty_set();
      test_field_extremes();
      test_unused_action();

      // Random part with idling.
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      test_fill_and_drain();
      test_random_mix(360, 1'b1);
      test_response_backpressure();

      // Closing part with no idling on either side.
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      test_random_mix(150, 1'b0);
      test_fill_and_drain();

      drain_responses();
      // Any stray beat after the last owed response is caught meanwhile.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d done, %0d no change,",
               requests_sent, responses_seen, status_seen[rss_pkg::ST_DONE],
               status_seen[rss_pkg::ST_NO_CHANGE]);
      $display("%0d full, %0d empty; peak of %0d members; longest request wait %0d cycles.",
               status_seen[rss_pkg::ST_FULL], status_seen[rss_pkg::ST_EMPTY],
               peak_members, longest_wait);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("testbench: clean");
      end else begin
         if (pending_responses.size() != 0)
            $error("%0d responses never arrived.", pending_responses.size());
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/rss_pkg.sv
src/rss_cell.sv
src/rss_mod.sv
src/random_sample_set.sv
tb/testbench.sv
